// ----- rtl/mi4_pkg.sv -----
package mi4_pkg;

  localparam int DIGIT_W    = 8;
  localparam int NUM_TERMS  = 76;
  localparam int TERM_IDX_W = 7;
  localparam int SCR_DEPTH  = 29;

  localparam logic [4:0] ADJ_BASE = 5'd12;
  localparam logic [4:0] DET_IDX  = 5'd28;

  typedef enum logic [3:0] {
    FR_LOAD,
    FR_ISSUE,
    FR_FETCH,
    FR_DIGIT,
    FR_ACCUM,
    FR_HOLD,
    FR_DREAD,
    FR_DSTART,
    FR_DWAIT
  } front_state_e;

  typedef enum logic [1:0] {
    OS_IDLE,
    OS_READ,
    OS_SHOW
  } out_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN,
    DV_DONE
  } div_state_e;

  // one signed product term: neg, serial element, operand is element, operand, target, last
  typedef struct packed {
    logic       neg;
    logic [3:0] mul_idx;
    logic       opd_elem;
    logic [4:0] opd_idx;
    logic [4:0] dst;
    logic       last;
  } term_t;

  localparam term_t TERM_ROM [NUM_TERMS] = '{
    // 2x2 minors of the upper rows
    '{1'b0, 4'd0,  1'b1, 5'd5,  5'd0,  1'b0}, '{1'b1, 4'd4,  1'b1, 5'd1,  5'd0,  1'b1},
    '{1'b0, 4'd0,  1'b1, 5'd6,  5'd1,  1'b0}, '{1'b1, 4'd4,  1'b1, 5'd2,  5'd1,  1'b1},
    '{1'b0, 4'd0,  1'b1, 5'd7,  5'd2,  1'b0}, '{1'b1, 4'd4,  1'b1, 5'd3,  5'd2,  1'b1},
    '{1'b0, 4'd1,  1'b1, 5'd6,  5'd3,  1'b0}, '{1'b1, 4'd5,  1'b1, 5'd2,  5'd3,  1'b1},
    '{1'b0, 4'd1,  1'b1, 5'd7,  5'd4,  1'b0}, '{1'b1, 4'd5,  1'b1, 5'd3,  5'd4,  1'b1},
    '{1'b0, 4'd2,  1'b1, 5'd7,  5'd5,  1'b0}, '{1'b1, 4'd6,  1'b1, 5'd3,  5'd5,  1'b1},
    // 2x2 minors of the lower rows
    '{1'b0, 4'd8,  1'b1, 5'd13, 5'd6,  1'b0}, '{1'b1, 4'd12, 1'b1, 5'd9,  5'd6,  1'b1},
    '{1'b0, 4'd8,  1'b1, 5'd14, 5'd7,  1'b0}, '{1'b1, 4'd12, 1'b1, 5'd10, 5'd7,  1'b1},
    '{1'b0, 4'd8,  1'b1, 5'd15, 5'd8,  1'b0}, '{1'b1, 4'd12, 1'b1, 5'd11, 5'd8,  1'b1},
    '{1'b0, 4'd9,  1'b1, 5'd14, 5'd9,  1'b0}, '{1'b1, 4'd13, 1'b1, 5'd10, 5'd9,  1'b1},
    '{1'b0, 4'd9,  1'b1, 5'd15, 5'd10, 1'b0}, '{1'b1, 4'd13, 1'b1, 5'd11, 5'd10, 1'b1},
    '{1'b0, 4'd10, 1'b1, 5'd15, 5'd11, 1'b0}, '{1'b1, 4'd14, 1'b1, 5'd11, 5'd11, 1'b1},
    // adjugate, row-major
    '{1'b0, 4'd5,  1'b0, 5'd11, 5'd12, 1'b0}, '{1'b1, 4'd6,  1'b0, 5'd10, 5'd12, 1'b0},
    '{1'b0, 4'd7,  1'b0, 5'd9,  5'd12, 1'b1},
    '{1'b1, 4'd1,  1'b0, 5'd11, 5'd13, 1'b0}, '{1'b0, 4'd2,  1'b0, 5'd10, 5'd13, 1'b0},
    '{1'b1, 4'd3,  1'b0, 5'd9,  5'd13, 1'b1},
    '{1'b0, 4'd13, 1'b0, 5'd5,  5'd14, 1'b0}, '{1'b1, 4'd14, 1'b0, 5'd4,  5'd14, 1'b0},
    '{1'b0, 4'd15, 1'b0, 5'd3,  5'd14, 1'b1},
    '{1'b1, 4'd9,  1'b0, 5'd5,  5'd15, 1'b0}, '{1'b0, 4'd10, 1'b0, 5'd4,  5'd15, 1'b0},
    '{1'b1, 4'd11, 1'b0, 5'd3,  5'd15, 1'b1},
    '{1'b1, 4'd4,  1'b0, 5'd11, 5'd16, 1'b0}, '{1'b0, 4'd6,  1'b0, 5'd8,  5'd16, 1'b0},
    '{1'b1, 4'd7,  1'b0, 5'd7,  5'd16, 1'b1},
    '{1'b0, 4'd0,  1'b0, 5'd11, 5'd17, 1'b0}, '{1'b1, 4'd2,  1'b0, 5'd8,  5'd17, 1'b0},
    '{1'b0, 4'd3,  1'b0, 5'd7,  5'd17, 1'b1},
    '{1'b1, 4'd12, 1'b0, 5'd5,  5'd18, 1'b0}, '{1'b0, 4'd14, 1'b0, 5'd2,  5'd18, 1'b0},
    '{1'b1, 4'd15, 1'b0, 5'd1,  5'd18, 1'b1},
    '{1'b0, 4'd8,  1'b0, 5'd5,  5'd19, 1'b0}, '{1'b1, 4'd10, 1'b0, 5'd2,  5'd19, 1'b0},
    '{1'b0, 4'd11, 1'b0, 5'd1,  5'd19, 1'b1},
    '{1'b0, 4'd4,  1'b0, 5'd10, 5'd20, 1'b0}, '{1'b1, 4'd5,  1'b0, 5'd8,  5'd20, 1'b0},
    '{1'b0, 4'd7,  1'b0, 5'd6,  5'd20, 1'b1},
    '{1'b1, 4'd0,  1'b0, 5'd10, 5'd21, 1'b0}, '{1'b0, 4'd1,  1'b0, 5'd8,  5'd21, 1'b0},
    '{1'b1, 4'd3,  1'b0, 5'd6,  5'd21, 1'b1},
    '{1'b0, 4'd12, 1'b0, 5'd4,  5'd22, 1'b0}, '{1'b1, 4'd13, 1'b0, 5'd2,  5'd22, 1'b0},
    '{1'b0, 4'd15, 1'b0, 5'd0,  5'd22, 1'b1},
    '{1'b1, 4'd8,  1'b0, 5'd4,  5'd23, 1'b0}, '{1'b0, 4'd9,  1'b0, 5'd2,  5'd23, 1'b0},
    '{1'b1, 4'd11, 1'b0, 5'd0,  5'd23, 1'b1},
    '{1'b1, 4'd4,  1'b0, 5'd9,  5'd24, 1'b0}, '{1'b0, 4'd5,  1'b0, 5'd7,  5'd24, 1'b0},
    '{1'b1, 4'd6,  1'b0, 5'd6,  5'd24, 1'b1},
    '{1'b0, 4'd0,  1'b0, 5'd9,  5'd25, 1'b0}, '{1'b1, 4'd1,  1'b0, 5'd7,  5'd25, 1'b0},
    '{1'b0, 4'd2,  1'b0, 5'd6,  5'd25, 1'b1},
    '{1'b1, 4'd12, 1'b0, 5'd3,  5'd26, 1'b0}, '{1'b0, 4'd13, 1'b0, 5'd1,  5'd26, 1'b0},
    '{1'b1, 4'd14, 1'b0, 5'd0,  5'd26, 1'b1},
    '{1'b0, 4'd8,  1'b0, 5'd3,  5'd27, 1'b0}, '{1'b1, 4'd9,  1'b0, 5'd1,  5'd27, 1'b0},
    '{1'b0, 4'd10, 1'b0, 5'd0,  5'd27, 1'b1},
    // determinant along the top row
    '{1'b0, 4'd0,  1'b0, 5'd12, 5'd28, 1'b0}, '{1'b0, 4'd1,  1'b0, 5'd16, 5'd28, 1'b0},
    '{1'b0, 4'd2,  1'b0, 5'd20, 5'd28, 1'b0}, '{1'b0, 4'd3,  1'b0, 5'd24, 5'd28, 1'b1}
  };

endpackage

// ----- rtl/mi4_div.sv -----
module mi4_div
  import mi4_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16,
  parameter int SCR_W         = 132
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [SCR_W-1:0]         num_i,
  input  logic signed [SCR_W-1:0]         den_i,
  output logic                            done_o,
  output logic signed [ELEMENT_WIDTH-1:0] quot_o
);

  localparam int QW    = ELEMENT_WIDTH + 2;
  localparam int DIV_W = SCR_W + 2 * FRACTION_BITS + ELEMENT_WIDTH + 3;
  localparam int CNT_W = $clog2(QW);
  localparam logic [ELEMENT_WIDTH:0] MAX_MAG = {2'b00, {(ELEMENT_WIDTH-1){1'b1}}};
  localparam logic [ELEMENT_WIDTH:0] MIN_MAG = {2'b01, {(ELEMENT_WIDTH-1){1'b0}}};

  div_state_e st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic [SCR_W-1:0] an_q, an_d, ad_q, ad_d, num_mag, den_mag;
  logic [DIV_W-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [DIV_W:0] diff;
  logic [QW-1:0] q_q, q_d;
  logic [ELEMENT_WIDTH:0] qv;

  always_comb begin
    st_d = st_q;
    case (st_q)
      DV_IDLE: begin
        if (start_i) st_d = DV_PREP;
      end
      DV_PREP: st_d = DV_RUN;
      DV_RUN: begin
        if (cnt_q == CNT_W'(QW - 1)) st_d = DV_DONE;
      end
      DV_DONE: st_d = DV_IDLE;
      default: st_d = DV_IDLE;
    endcase
  end

  always_comb begin
    num_mag = num_i[SCR_W-1] ? -num_i : num_i;
    den_mag = den_i[SCR_W-1] ? -den_i : den_i;
    diff    = {1'b0, rem_q} - {1'b0, dsh_q};
    qv      = q_q[QW-2:0];
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    an_d    = an_q;
    ad_d    = ad_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    q_d     = q_q;
    done_o  = 1'b0;
    case (st_q)
      DV_IDLE: begin
        neg_d = num_i[SCR_W-1] ^ den_i[SCR_W-1];
        an_d  = num_mag;
        ad_d  = den_mag;
      end
      DV_PREP: begin
        rem_d = (DIV_W'(an_q) << (2 * FRACTION_BITS + 1)) + DIV_W'(ad_q);
        dsh_d = DIV_W'(ad_q) << (ELEMENT_WIDTH + 2);
        cnt_d = '0;
      end
      DV_RUN: begin
        if (!diff[DIV_W]) rem_d = diff[DIV_W-1:0];
        q_d   = {q_q[QW-2:0], ~diff[DIV_W]};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
      end
      DV_DONE: done_o = 1'b1;
      default: ;
    endcase
    // rounding already folded in, saturate to the element range
    if (!neg_q) begin
      if (q_q[QW-1] || (qv > MAX_MAG)) quot_o = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      else quot_o = qv[ELEMENT_WIDTH-1:0];
    end else begin
      if (q_q[QW-1] || (qv > MIN_MAG)) quot_o = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
      else quot_o = -qv[ELEMENT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DV_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    q_q   <= q_d;
  end

endmodule

// ----- rtl/matrix4_inverse_adjugate_core.sv -----
// 4x4 matrix inverse by cofactors over the exact determinant, signed fixed point.
// Input channel: element_in_i with in_valid_i / in_stall_o, sixteen requests per
// matrix in row-major order. Output channel: element_out_o, singular_o and
// last_element_o with out_valid_o / out_stall_i, sixteen requests per matrix in
// row-major order, last_element_o marking the sixteenth.
// Loading accepts one element per cycle. After the sixteenth, a shared serial
// multiplier works through 76 product terms of the cofactor expansion, each term
// going through issue, operand fetch, one step per 8-bit digit, and accumulation,
// then a bit-serial divider forms each of the 16 quotients in turn.
// A zero determinant skips the divider and gives identity with singular_o set.
// Results stream from the inverse memory, each read before it is shown; the next
// matrix may load meanwhile, and its computation waits at the end of the cofactor
// pass until the previous results have all gone out.
// A stalled result holds on the outputs until taken.
// Reset returns to loading at element zero with no result pending; memory
// contents are not cleared.
module matrix4_inverse_adjugate_core
  import mi4_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [ELEMENT_WIDTH-1:0] element_in_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output logic signed [ELEMENT_WIDTH-1:0] element_out_o,
  output logic                            singular_o,
  output logic                            last_element_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i
);

  localparam int EXT_W  = ((ELEMENT_WIDTH + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int NDIG   = EXT_W / DIGIT_W;
  localparam int DCNT_W = $clog2(NDIG);
  localparam int SCR_W  = 4 * ELEMENT_WIDTH + 4;
  localparam logic [ELEMENT_WIDTH-1:0] ONE_VAL = (FRACTION_BITS < ELEMENT_WIDTH - 1) ?
      (ELEMENT_WIDTH'(1) << FRACTION_BITS) : {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};

  front_state_e fr_q, fr_d;
  out_state_e os_q, os_d;
  logic [3:0] load_cnt_q, load_cnt_d, div_k_q, div_k_d, out_idx_q, out_idx_d;
  logic [TERM_IDX_W-1:0] term_q, term_d;
  logic [DCNT_W-1:0] dig_q, dig_d;
  logic [EXT_W-1:0] mul_q, mul_d;
  logic signed [SCR_W-1:0] opd_q, opd_d, prod_q, prod_d, acc_q, acc_d, det_q, det_d;
  logic signed [SCR_W-1:0] part, acc_sum;
  logic signed [DIGIT_W:0] dig_x;
  logic sing_q, sing_d;
  term_t cur;

  logic signed [ELEMENT_WIDTH-1:0] mat_mem [16];
  logic signed [ELEMENT_WIDTH-1:0] mat_a_q, mat_b_q;
  logic [3:0] mat_a_addr, mat_b_addr;
  logic signed [SCR_W-1:0] scr_mem [SCR_DEPTH];
  logic signed [SCR_W-1:0] scr_rd_q;
  logic [4:0] scr_raddr;
  logic scr_we;
  logic signed [ELEMENT_WIDTH-1:0] inv_mem [16];
  logic signed [ELEMENT_WIDTH-1:0] inv_rd_q, inv_wdata, div_quot;
  logic inv_we, div_start, div_done, stream_start, in_accept;

  assign in_stall_o = (fr_q != FR_LOAD);
  assign in_accept  = in_valid_i && (fr_q == FR_LOAD);

  mi4_div #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS),
    .SCR_W        (SCR_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (scr_rd_q),
    .den_i  (det_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    fr_d = fr_q;
    case (fr_q)
      FR_LOAD: begin
        if (in_accept && (load_cnt_q == 4'd15)) fr_d = FR_ISSUE;
      end
      FR_ISSUE: fr_d = FR_FETCH;
      FR_FETCH: fr_d = FR_DIGIT;
      FR_DIGIT: begin
        if (dig_q == DCNT_W'(NDIG - 1)) fr_d = FR_ACCUM;
      end
      FR_ACCUM: begin
        if (term_q == TERM_IDX_W'(NUM_TERMS - 1)) fr_d = FR_HOLD;
        else fr_d = FR_ISSUE;
      end
      FR_HOLD: begin
        if (os_q == OS_IDLE) fr_d = FR_DREAD;
      end
      FR_DREAD: fr_d = FR_DSTART;
      FR_DSTART: begin
        if (!sing_q) fr_d = FR_DWAIT;
        else if (div_k_q == 4'd15) fr_d = FR_LOAD;
        else fr_d = FR_DREAD;
      end
      FR_DWAIT: begin
        if (div_done) fr_d = (div_k_q == 4'd15) ? FR_LOAD : FR_DREAD;
      end
      default: fr_d = FR_LOAD;
    endcase
  end

  always_comb begin
    cur          = TERM_ROM[term_q];
    mat_a_addr   = cur.mul_idx;
    mat_b_addr   = cur.opd_idx[3:0];
    scr_raddr    = cur.opd_idx;
    dig_x        = {(dig_q == '0) & mul_q[EXT_W-1], mul_q[EXT_W-1 -: DIGIT_W]};
    part         = opd_q * dig_x;
    acc_sum      = cur.neg ? (acc_q - prod_q) : (acc_q + prod_q);
    load_cnt_d   = load_cnt_q;
    term_d       = term_q;
    dig_d        = dig_q;
    mul_d        = mul_q;
    opd_d        = opd_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    det_d        = det_q;
    sing_d       = sing_q;
    div_k_d      = div_k_q;
    scr_we       = 1'b0;
    inv_we       = 1'b0;
    inv_wdata    = div_quot;
    div_start    = 1'b0;
    stream_start = 1'b0;
    case (fr_q)
      FR_LOAD: begin
        if (in_accept) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_q == 4'd15) begin
            term_d = '0;
            acc_d  = '0;
          end
        end
      end
      FR_FETCH: begin
        mul_d  = EXT_W'(mat_a_q);
        opd_d  = cur.opd_elem ? SCR_W'(mat_b_q) : scr_rd_q;
        prod_d = '0;
        dig_d  = '0;
      end
      FR_DIGIT: begin
        prod_d = (prod_q << DIGIT_W) + part;
        mul_d  = mul_q << DIGIT_W;
        dig_d  = dig_q + 1'b1;
      end
      FR_ACCUM: begin
        acc_d = acc_sum;
        if (cur.last) begin
          scr_we = 1'b1;
          acc_d  = '0;
          if (cur.dst == DET_IDX) det_d = acc_sum;
        end
        if (term_q == TERM_IDX_W'(NUM_TERMS - 1)) term_d = '0;
        else term_d = term_q + 1'b1;
      end
      FR_HOLD: begin
        if (os_q == OS_IDLE) begin
          sing_d  = (det_q == '0);
          div_k_d = '0;
        end
      end
      FR_DREAD: scr_raddr = ADJ_BASE + {1'b0, div_k_q};
      FR_DSTART: begin
        scr_raddr = ADJ_BASE + {1'b0, div_k_q};
        if (sing_q) begin
          inv_we       = 1'b1;
          inv_wdata    = (div_k_q[3:2] == div_k_q[1:0]) ? ONE_VAL : '0;
          div_k_d      = div_k_q + 1'b1;
          stream_start = (div_k_q == 4'd15);
        end else begin
          div_start = 1'b1;
        end
      end
      FR_DWAIT: begin
        if (div_done) begin
          inv_we       = 1'b1;
          div_k_d      = div_k_q + 1'b1;
          stream_start = (div_k_q == 4'd15);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    os_d = os_q;
    case (os_q)
      OS_IDLE: begin
        if (stream_start) os_d = OS_READ;
      end
      OS_READ: os_d = OS_SHOW;
      OS_SHOW: begin
        if (!out_stall_i) os_d = (out_idx_q == 4'd15) ? OS_IDLE : OS_READ;
      end
      default: os_d = OS_IDLE;
    endcase
  end

  always_comb begin
    out_idx_d      = out_idx_q;
    out_valid_o    = (os_q == OS_SHOW);
    element_out_o  = inv_rd_q;
    singular_o     = sing_q;
    last_element_o = (out_idx_q == 4'd15);
    if ((os_q == OS_SHOW) && !out_stall_i) out_idx_d = out_idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q       <= FR_LOAD;
      os_q       <= OS_IDLE;
      load_cnt_q <= '0;
      term_q     <= '0;
      dig_q      <= '0;
      div_k_q    <= '0;
      out_idx_q  <= '0;
      sing_q     <= 1'b0;
    end else begin
      fr_q       <= fr_d;
      os_q       <= os_d;
      load_cnt_q <= load_cnt_d;
      term_q     <= term_d;
      dig_q      <= dig_d;
      div_k_q    <= div_k_d;
      out_idx_q  <= out_idx_d;
      sing_q     <= sing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q  <= mul_d;
    opd_q  <= opd_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    det_q  <= det_d;
  end

  // matrix memory, two read ports
  always_ff @(posedge clk_i) begin
    if (in_accept) mat_mem[load_cnt_q] <= element_in_i;
    mat_a_q <= mat_mem[mat_a_addr];
    mat_b_q <= mat_mem[mat_b_addr];
  end

  // minors, adjugate and determinant
  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[cur.dst] <= acc_sum;
    scr_rd_q <= scr_mem[scr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) inv_mem[div_k_q] <= inv_wdata;
    if (os_q == OS_READ) inv_rd_q <= inv_mem[out_idx_q];
  end

endmodule

// ----- tb/sv/tb_matrix4_inverse_adjugate_core.sv -----
`timescale 1ns / 100ps

module tb_matrix4_inverse_adjugate_core;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int WW = 256;
  localparam int NUM_MATRICES = 19;

  typedef struct packed {
    logic [EW-1:0] element;
    logic          singular;
    logic          last;
  } inv_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic signed [EW-1:0] element_in_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [EW-1:0] element_out_o;
  logic                 singular_o;
  logic                 last_element_o;
  logic                 out_valid_o;
  logic                 out_stall_i;

  logic [EW-1:0]  pending_elements[$];
  inv_result_t    expected_inverse[$];
  logic [EW-1:0]  loaded_matrix[16];
  int             load_index;
  int             mismatch_count;
  bit             stimulus_done;
  bit             calm_phase;
  bit             hold_sender;
  int             send_gap;
  int             recv_gap;

  matrix4_inverse_adjugate_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .element_in_i   (element_in_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_out_o  (element_out_o),
    .singular_o     (singular_o),
    .last_element_o (last_element_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic signed [WW-1:0] mat_at(int r, int c);
    return WW'($signed(loaded_matrix[r*4+c]));
  endfunction

  function automatic logic signed [WW-1:0] minor3(int skip_r, int skip_c);
    int rs[3];
    int cs[3];
    int nr;
    int nc;
    logic signed [WW-1:0] t0, t1, t2;
    nr = 0;
    nc = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != skip_r) begin rs[nr] = k; nr++; end
      if (k != skip_c) begin cs[nc] = k; nc++; end
    end
    t0 = mat_at(rs[1], cs[1]) * mat_at(rs[2], cs[2]) - mat_at(rs[1], cs[2]) * mat_at(rs[2], cs[1]);
    t1 = mat_at(rs[1], cs[0]) * mat_at(rs[2], cs[2]) - mat_at(rs[1], cs[2]) * mat_at(rs[2], cs[0]);
    t2 = mat_at(rs[1], cs[0]) * mat_at(rs[2], cs[1]) - mat_at(rs[1], cs[1]) * mat_at(rs[2], cs[0]);
    minor3 = mat_at(rs[0], cs[0]) * t0 - mat_at(rs[0], cs[1]) * t1 + mat_at(rs[0], cs[2]) * t2;
    if (((skip_r + skip_c) & 1) != 0) minor3 = -minor3;
  endfunction

  // rounded, ties away from zero, saturated
  function automatic logic [EW-1:0] scaled_quotient(logic signed [WW-1:0] cof,
                                                    logic signed [WW-1:0] det);
    logic          neg;
    logic [WW-1:0] ac, ad, q;
    logic [WW-1:0] max_pos;
    neg = cof[WW-1] ^ det[WW-1];
    ac = cof[WW-1] ? -cof : cof;
    ad = det[WW-1] ? -det : det;
    q = ((ac << (2*FB + 1)) + ad) / (ad << 1);
    max_pos = (WW'(1) << (EW-1)) - 1;
    if (!neg) begin
      if (q > max_pos) q = max_pos;
      return q[EW-1:0];
    end
    if (q > max_pos + 1) q = max_pos + 1;
    return EW'(-q);
  endfunction

  task automatic predict_inverse();
    logic signed [WW-1:0] cof[16];
    logic signed [WW-1:0] det;
    inv_result_t          res;
    for (int k = 0; k < 16; k++) cof[k] = minor3(k / 4, k % 4);
    det = '0;
    for (int k = 0; k < 4; k++) det += mat_at(0, k) * cof[k];
    for (int k = 0; k < 16; k++) begin
      res.singular = (det == 0);
      res.last     = (k == 15);
      if (res.singular) res.element = ((k / 4) == (k % 4)) ? EW'(1 << FB) : '0;
      else res.element = scaled_quotient(cof[(k % 4) * 4 + k / 4], det);
      expected_inverse.push_back(res);
    end
  endtask

  function automatic logic [EW-1:0] random_element(int mode);
    case (mode)
      0: return $urandom();
      1: return EW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      2: return EW'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic add_matrix(logic [EW-1:0] m[16]);
    for (int k = 0; k < 16; k++) pending_elements.push_back(m[k]);
  endtask

  initial begin
    logic [EW-1:0] m[16];
    int mode;
    rst_ni = 1'b0;
    stimulus_done = 1'b0;
    calm_phase = 1'b0;
    hold_sender = 1'b0;
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? EW'(1 << FB) : '0;
    add_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = '0;
    add_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0000_0001 : '0;
    add_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h8000_0000 : '0;
    add_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h7fff_ffff : 32'hffff_ffff;
    add_matrix(m);
    // rounding tie: diagonal of two gives a half-unit quotient at element one
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? EW'(2 << FB) : ((k == 1) ? EW'(2) : '0);
    add_matrix(m);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_elements.size() == 0 && !in_valid_i);
    hold_sender = 1'b1;
    wait (expected_inverse.size() == 0);
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    for (int n = 0; n < NUM_MATRICES; n++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 16; k++) m[k] = random_element(mode);
      if ($urandom_range(0, 5) == 0) for (int k = 0; k < 4; k++) m[4+k] = m[k];
      add_matrix(m);
    end
    wait (pending_elements.size() <= 3 * 16);
    calm_phase = 1'b1;
    wait (pending_elements.size() == 0 && !in_valid_i);
    stimulus_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      element_in_i <= '0;
      send_gap     <= 0;
      load_index   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        loaded_matrix[load_index] = element_in_i;
        load_index++;
        if (load_index == 16) begin
          load_index = 0;
          predict_inverse();
        end
      end
      if (in_valid_i && in_stall_o) begin
      end else if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        send_gap   <= $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (pending_elements.size() > 0 && !hold_sender) begin
        in_valid_i   <= 1'b1;
        element_in_i <= pending_elements.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    inv_result_t want;
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      recv_gap       <= 0;
      mismatch_count = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_inverse.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", element_out_o);
        end else begin
          want = expected_inverse.pop_front();
          if (want.element !== element_out_o || want.singular !== singular_o
              || want.last !== last_element_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h/%b/%b got %h/%b/%b", want.element,
                       want.singular, want.last, element_out_o, singular_o, last_element_o);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        recv_gap    <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_inverse.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (mismatch_count == 0 && expected_inverse.size() == 0)
      $display("matrix4_inverse_adjugate_core regression: pass");
    else
      $display("matrix4_inverse_adjugate_core regression: fail");
    $finish;
  end

  initial begin
    #1000000;
    $display("matrix4_inverse_adjugate_core regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mi4_pkg.sv
rtl/mi4_div.sv
rtl/matrix4_inverse_adjugate_core.sv
tb/sv/tb_matrix4_inverse_adjugate_core.sv
